/* design/eqlf_pkg.sv */
// shared types, constants and the fit step table of the even quadratic fit core
`default_nettype none

package eqlf_pkg;

  localparam int unsigned POINTS_MAX = 8;
  localparam int unsigned CNT_W      = 5;

  localparam int unsigned X_W    = 12;
  localparam int unsigned F_W    = 16;
  localparam int unsigned COEF_W = 32;

  localparam int unsigned XX_W   = 23;
  localparam int unsigned SF_W   = 21;
  localparam int unsigned SXX_W  = 27;
  localparam int unsigned SX4_W  = 49;
  localparam int unsigned SFXX_W = 42;

  localparam int unsigned OPA_W  = 28;
  localparam int unsigned OPB_W  = 24;
  localparam int unsigned PROD_W = 53;
  localparam int unsigned ACC_W  = 80;
  localparam int unsigned SH_W   = 5;

  localparam int unsigned NUM_W     = 71;
  localparam int unsigned DET_W     = 53;
  localparam int unsigned DIV_W     = 78;
  localparam int unsigned DIV_CNT_W = 7;
  localparam int unsigned Q_W       = 33;

  localparam int unsigned FIT_ST_W  = 4;
  localparam int unsigned FIT_DET   = 5;
  localparam int unsigned FIT_NUM0  = 9;
  localparam int unsigned FIT_END   = 12;

  localparam logic [SH_W-1:0] SH_NUM0 = SH_W'(8);
  localparam logic [SH_W-1:0] SH_NUM2 = SH_W'(24);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_X4,
    S_FXX,
    S_ACC,
    S_FIT,
    S_DIV0_GO,
    S_DIV0,
    S_DIV1_GO,
    S_DIV1,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    A_ZERO,
    A_ABSX,
    A_PRODXX,
    A_XX,
    A_X4LO,
    A_X4HI,
    A_SXX,
    A_N
  } a_sel_e;

  typedef enum logic [3:0] {
    B_ZERO,
    B_ABSX,
    B_PRODXX,
    B_F,
    B_N,
    B_SF,
    B_SXXLO,
    B_SXXHI,
    B_FXXLO,
    B_FXXHI
  } b_sel_e;

  typedef struct packed {
    logic            en;
    logic            first;
    logic            sub;
    logic [SH_W-1:0] shift;
  } mac_ctrl_t;

  typedef struct packed {
    a_sel_e    a_sel;
    b_sel_e    b_sel;
    mac_ctrl_t ctrl;
  } fit_op_t;

  typedef struct packed {
    logic done;
    logic clip;
  } div_stat_t;

  // det, then the c0 numerator, then the c2 numerator, each a signed sum of limb products
  function automatic fit_op_t fit_op(input logic [FIT_ST_W-1:0] step);
    fit_op_t op;
    op = '{a_sel: A_ZERO, b_sel: B_ZERO, ctrl: '{en: 1'b0, first: 1'b0, sub: 1'b0, shift: '0}};
    case (step)
      4'd0:  op = '{A_X4LO, B_N,     '{1'b1, 1'b1, 1'b0, SH_W'(0)}};
      4'd1:  op = '{A_X4HI, B_N,     '{1'b1, 1'b0, 1'b0, SH_W'(25)}};
      4'd2:  op = '{A_SXX,  B_SXXLO, '{1'b1, 1'b0, 1'b1, SH_W'(0)}};
      4'd3:  op = '{A_SXX,  B_SXXHI, '{1'b1, 1'b0, 1'b1, SH_W'(14)}};
      4'd4:  op = '{A_X4LO, B_SF,    '{1'b1, 1'b1, 1'b0, SH_W'(0)}};
      4'd5:  op = '{A_X4HI, B_SF,    '{1'b1, 1'b0, 1'b0, SH_W'(25)}};
      4'd6:  op = '{A_SXX,  B_FXXLO, '{1'b1, 1'b0, 1'b1, SH_W'(0)}};
      4'd7:  op = '{A_SXX,  B_FXXHI, '{1'b1, 1'b0, 1'b1, SH_W'(21)}};
      4'd8:  op = '{A_N,    B_FXXLO, '{1'b1, 1'b1, 1'b0, SH_W'(0)}};
      4'd9:  op = '{A_N,    B_FXXHI, '{1'b1, 1'b0, 1'b0, SH_W'(21)}};
      4'd10: op = '{A_SXX,  B_SF,    '{1'b1, 1'b0, 1'b1, SH_W'(0)}};
      default: op = '{a_sel: A_ZERO, b_sel: B_ZERO,
                      ctrl: '{en: 1'b0, first: 1'b0, sub: 1'b0, shift: '0}};
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

/* design/even_quadratic_lsq_fit_core.sv */
// top level of the even quadratic least-squares fit core
//
// sample points enter on the s_axis channel, one request per point: tdata carries
// x (signed Q4.8) and f (signed Q8.8), tlast marks the final point of a set.
// each point with room in the set is accepted, then takes four steps through the
// shared multiplier; points beyond POINTS_MAX are dropped on acceptance.
// a last point then starts the fit: limb products through the same multiplier and
// accumulator, then two restoring divisions, one quotient bit a cycle; a singular
// set skips the divisions and goes straight to the result.
// the result request on m_axis carries c0 and c2 as signed Q16.16 in tdata and the
// singular and clipped flags in tuser; it sits in an output register, so the next
// set is accepted while the result waits. the fit only stalls when a second result
// is ready while the first is still held by the receiver.
// reset clears the sums, the point count and the output valid at once.
`default_nettype none

module even_quadratic_lsq_fit_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [31:0] s_axis_tdata_i,   // sample_x [11:0], sample_f [27:12], zero [31:28]
  input  wire         s_axis_tlast_i,   // last_sample
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // coef_const [31:0], coef_square [63:32]
  output logic [1:0]  m_axis_tuser_o    // singular [0], clipped [1]
);
  import eqlf_pkg::*;

  state_e state_q, state_d;

  logic [X_W-1:0]      x_q;
  logic [F_W-1:0]      f_q;
  logic                last_q;
  logic [X_W-1:0]      abs_x;
  logic [XX_W-1:0]     xx_q;

  logic [CNT_W-1:0]    cnt_q;
  logic [SF_W-1:0]     sf_q;
  logic [SXX_W-1:0]    sxx_q;
  logic [SX4_W-1:0]    sx4_q;
  logic [SFXX_W-1:0]   sfxx_q;

  logic [FIT_ST_W-1:0] fit_st_q;
  logic [DET_W-1:0]    det_q;
  logic                det_bad_q;
  logic [NUM_W-1:0]    num0_q;
  logic [COEF_W-1:0]   c0_q, c2_q;
  logic                clip_q;

  logic                out_valid_q;
  logic [COEF_W-1:0]   coef_const_q, coef_square_q;
  logic                singular_q, clipped_q;

  a_sel_e              a_sel;
  b_sel_e              b_sel;
  mac_ctrl_t           mac_ctrl;
  fit_op_t             op;
  logic [OPA_W-1:0]    opa;
  logic signed [OPB_W-1:0] opb;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic                div_start;
  logic [NUM_W-1:0]    div_num;
  logic [SH_W-1:0]     div_sh;
  div_stat_t           div_stat;
  logic [COEF_W-1:0]   div_quot;

  logic                accept;
  logic                has_room;
  logic                out_load;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign has_room = cnt_q < CNT_W'(POINTS_MAX);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);
  assign abs_x    = x_q[X_W-1] ? X_W'(~x_q + X_W'(1)) : x_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (has_room) begin
            state_d = S_SQ;
          end else if (s_axis_tlast_i) begin
            state_d = S_FIT;
          end
        end
      end
      S_SQ:  state_d = S_X4;
      S_X4:  state_d = S_FXX;
      S_FXX: state_d = S_ACC;
      S_ACC: state_d = last_q ? S_FIT : S_IDLE;
      S_FIT: begin
        if (fit_st_q == FIT_ST_W'(FIT_END)) begin
          state_d = det_bad_q ? S_DONE : S_DIV0_GO;
        end
      end
      S_DIV0_GO: state_d = S_DIV0;
      S_DIV0:    state_d = div_stat.done ? S_DIV1_GO : S_DIV0;
      S_DIV1_GO: state_d = S_DIV1;
      S_DIV1:    state_d = div_stat.done ? S_DONE : S_DIV1;
      S_DONE:    state_d = out_load ? S_IDLE : S_DONE;
      default:   state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    a_sel           = A_ZERO;
    b_sel           = B_ZERO;
    mac_ctrl        = '0;
    div_start       = 1'b0;
    div_num         = num0_q;
    div_sh          = SH_NUM0;
    op              = fit_op(fit_st_q);
    case (state_q)
      S_IDLE: s_axis_tready_o = 1'b1;
      S_SQ: begin
        a_sel = A_ABSX;
        b_sel = B_ABSX;
      end
      S_X4: begin
        a_sel = A_PRODXX;
        b_sel = B_PRODXX;
      end
      S_FXX: begin
        a_sel = A_XX;
        b_sel = B_F;
      end
      S_FIT: begin
        a_sel    = op.a_sel;
        b_sel    = op.b_sel;
        mac_ctrl = op.ctrl;
      end
      S_DIV0_GO: div_start = 1'b1;
      S_DIV1_GO: begin
        div_start = 1'b1;
        div_num   = acc[NUM_W-1:0];
        div_sh    = SH_NUM2;
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    case (a_sel)
      A_ABSX:   opa = OPA_W'(abs_x);
      A_PRODXX: opa = OPA_W'(prod[XX_W-1:0]);
      A_XX:     opa = OPA_W'(xx_q);
      A_X4LO:   opa = OPA_W'(sx4_q[24:0]);
      A_X4HI:   opa = OPA_W'(sx4_q[SX4_W-1:25]);
      A_SXX:    opa = OPA_W'(sxx_q);
      A_N:      opa = OPA_W'(cnt_q);
      default:  opa = '0;
    endcase
    case (b_sel)
      B_ABSX:   opb = $signed(OPB_W'(abs_x));
      B_PRODXX: opb = $signed(OPB_W'(prod[XX_W-1:0]));
      B_F:      opb = $signed({{(OPB_W-F_W){f_q[F_W-1]}}, f_q});
      B_N:      opb = $signed(OPB_W'(cnt_q));
      B_SF:     opb = $signed({{(OPB_W-SF_W){sf_q[SF_W-1]}}, sf_q});
      B_SXXLO:  opb = $signed(OPB_W'(sxx_q[13:0]));
      B_SXXHI:  opb = $signed(OPB_W'(sxx_q[SXX_W-1:14]));
      B_FXXLO:  opb = $signed(OPB_W'(sfxx_q[20:0]));
      B_FXXHI:  opb = $signed({{3{sfxx_q[SFXX_W-1]}}, sfxx_q[SFXX_W-1:21]});
      default:  opb = '0;
    endcase
  end

  eqlf_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (opa),
    .b_i    (opb),
    .ctrl_i (mac_ctrl),
    .prod_o (prod),
    .acc_o  (acc)
  );

  eqlf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .sh_i    (div_sh),
    .det_i   (det_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  // control state and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sf_q        <= '0;
      sxx_q       <= '0;
      sx4_q       <= '0;
      sfxx_q      <= '0;
      fit_st_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIT) begin
        fit_st_q <= fit_st_q + FIT_ST_W'(1);
      end else begin
        fit_st_q <= '0;
      end
      case (state_q)
        S_X4: begin
          sxx_q <= sxx_q + SXX_W'(prod[XX_W-1:0]);
          sf_q  <= sf_q + {{(SF_W-F_W){f_q[F_W-1]}}, f_q};
        end
        S_FXX: sx4_q  <= sx4_q + prod[SX4_W-1:0];
        S_ACC: begin
          sfxx_q <= sfxx_q + prod[SFXX_W-1:0];
          cnt_q  <= cnt_q + CNT_W'(1);
        end
        S_DONE: begin
          if (out_load) begin
            cnt_q  <= '0;
            sf_q   <= '0;
            sxx_q  <= '0;
            sx4_q  <= '0;
            sfxx_q <= '0;
          end
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= s_axis_tdata_i[X_W-1:0];
      f_q    <= s_axis_tdata_i[X_W+F_W-1:X_W];
      last_q <= s_axis_tlast_i;
    end
    if (state_q == S_X4) begin
      xx_q <= prod[XX_W-1:0];
    end
    if (state_q == S_FIT && fit_st_q == FIT_ST_W'(FIT_DET)) begin
      det_q     <= acc[DET_W-1:0];
      det_bad_q <= acc[ACC_W-1] | (acc == '0);
    end
    if (state_q == S_FIT && fit_st_q == FIT_ST_W'(FIT_NUM0)) begin
      num0_q <= acc[NUM_W-1:0];
    end
    if (state_q == S_DIV0 && div_stat.done) begin
      c0_q   <= div_quot;
      clip_q <= div_stat.clip;
    end
    if (state_q == S_DIV1 && div_stat.done) begin
      c2_q   <= div_quot;
      clip_q <= clip_q | div_stat.clip;
    end
    if (out_load) begin
      coef_const_q  <= det_bad_q ? '0 : c0_q;
      coef_square_q <= det_bad_q ? '0 : c2_q;
      singular_q    <= det_bad_q;
      clipped_q     <= det_bad_q ? 1'b0 : clip_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {coef_square_q, coef_const_q};
  assign m_axis_tuser_o  = {clipped_q, singular_q};

endmodule

`default_nettype wire

/* design/eqlf_mac.sv */
// shared multiplier with a shifting wide accumulator
`default_nettype none

module eqlf_mac (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire  [eqlf_pkg::OPA_W-1:0]            a_i,
  input  wire  signed [eqlf_pkg::OPB_W-1:0]     b_i,
  input  eqlf_pkg::mac_ctrl_t                   ctrl_i,
  output logic signed [eqlf_pkg::PROD_W-1:0]    prod_o,
  output logic signed [eqlf_pkg::ACC_W-1:0]     acc_o
);
  import eqlf_pkg::*;

  logic signed [PROD_W-1:0] prod_d, prod_q;
  mac_ctrl_t                ctrl_q;
  logic signed [ACC_W-1:0]  acc_d, acc_q;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  base;

  assign prod_d = $signed(PROD_W'({1'b0, a_i})) * PROD_W'(b_i);

  // the accumulate control is registered alongside the product, so it acts in the cycle after its operands
  always_comb begin
    term  = $signed({{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q}) <<< ctrl_q.shift;
    base  = ctrl_q.first ? '0 : acc_q;
    acc_d = ctrl_q.sub ? base - term : base + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctrl_q.en) begin
      acc_q <= acc_d;
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

/* design/eqlf_div.sv */
// restoring divider, one quotient bit a cycle, with signed saturation to 32 bits
`default_nettype none

module eqlf_div (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start_i,
  input  wire  signed [eqlf_pkg::NUM_W-1:0]    num_i,
  input  wire  [eqlf_pkg::SH_W-1:0]            sh_i,
  input  wire  [eqlf_pkg::DET_W-1:0]           det_i,
  output eqlf_pkg::div_stat_t                  stat_o,
  output logic [eqlf_pkg::COEF_W-1:0]          quot_o
);
  import eqlf_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     dvd_q;
  logic [DET_W-1:0]     rem_q, rem_d;
  logic [Q_W-1:0]       q_q;
  logic                 sticky_q, neg_q;
  logic [NUM_W-1:0]     mag;
  logic [DIV_W-1:0]     dvd_load;
  logic [DET_W:0]       trial;
  logic                 ge;
  logic [Q_W-1:0]       limit;
  logic                 over;
  logic [COEF_W-1:0]    mag32;

  always_comb begin
    mag      = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
    dvd_load = DIV_W'(mag) << sh_i;
    trial    = {rem_q, dvd_q[DIV_W-1]};
    ge       = trial >= {1'b0, det_i};
    rem_d    = ge ? DET_W'(trial - {1'b0, det_i}) : trial[DET_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q    <= dvd_load;
      rem_q    <= '0;
      q_q      <= '0;
      sticky_q <= 1'b0;
      neg_q    <= num_i[NUM_W-1];
    end else if (busy_q) begin
      dvd_q    <= {dvd_q[DIV_W-2:0], 1'b0};
      rem_q    <= rem_d;
      q_q      <= {q_q[Q_W-2:0], ge};
      sticky_q <= sticky_q | q_q[Q_W-1];
    end
  end

  // negative side may reach 2^31, positive side stops at 2^31 - 1
  always_comb begin
    limit  = neg_q ? Q_W'(33'h080000000) : Q_W'(33'h07fffffff);
    over   = sticky_q | (q_q > limit);
    mag32  = over ? limit[COEF_W-1:0] : q_q[COEF_W-1:0];
    quot_o = neg_q ? COEF_W'(-mag32) : mag32;
  end

  assign stat_o = '{done: done_q, clip: over};

endmodule

`default_nettype wire

/* verif/testbench.sv */
// self-checking testbench for the even quadratic least-squares fit core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import eqlf_pkg::*;

  localparam int unsigned SET_POINTS = 1250;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam logic signed [127:0] Q16_MAX = 128'sd2147483647;
  localparam logic signed [127:0] Q16_MIN = -128'sd2147483648;

  typedef struct packed {
    logic [COEF_W-1:0] c0;
    logic [COEF_W-1:0] c2;
    logic              singular;
    logic              clipped;
  } fit_res_t;

  function automatic logic [COEF_W-1:0] clamp_q16(input logic signed [127:0] q);
    if (q > Q16_MAX) return 32'h7FFF_FFFF;
    if (q < Q16_MIN) return 32'h8000_0000;
    return q[COEF_W-1:0];
  endfunction

  function automatic logic out_of_q16(input logic signed [127:0] q);
    return (q > Q16_MAX) || (q < Q16_MIN);
  endfunction

  // running sums of the current set and the fits they lead to
  class lsq_fit_tracker;
    int unsigned               held;
    logic signed [SF_W-1:0]    sum_f;
    logic [SXX_W-1:0]          sum_xx;
    logic [SX4_W-1:0]          sum_x4;
    logic signed [SFXX_W-1:0]  sum_fxx;
    fit_res_t                  pending_fits[$];
    int unsigned               errors;

    function new();
      errors = 0;
      clear_set();
    endfunction

    function void clear_set();
      held    = 0;
      sum_f   = '0;
      sum_xx  = '0;
      sum_x4  = '0;
      sum_fxx = '0;
    endfunction

    function void take_point(input logic signed [X_W-1:0] x,
                             input logic signed [F_W-1:0] f, input logic last_pt);
      logic signed [127:0] xw, fw, xx, x4, fxx;
      logic signed [127:0] n, sf, sxx, sx4, sfxx, det, q0, q2;
      fit_res_t fit;
      xw  = 128'(x);
      fw  = 128'(f);
      xx  = xw * xw;
      x4  = xx * xx;
      fxx = fw * xx;
      // a full set drops the point but still honours its last mark
      if (held < POINTS_MAX) begin
        held++;
        sum_f   = sum_f + fw[SF_W-1:0];
        sum_xx  = sum_xx + xx[SXX_W-1:0];
        sum_x4  = sum_x4 + x4[SX4_W-1:0];
        sum_fxx = sum_fxx + fxx[SFXX_W-1:0];
      end
      if (!last_pt) return;
      n    = 128'(held);
      sf   = 128'(sum_f);
      sxx  = 128'(sum_xx);
      sx4  = 128'(sum_x4);
      sfxx = 128'(sum_fxx);
      det  = n * sx4 - sxx * sxx;
      if (det <= 0) begin
        fit = '{c0: '0, c2: '0, singular: 1'b1, clipped: 1'b0};
      end else begin
        // signed division truncates toward zero, as the divider does
        q0 = ((sx4 * sf - sxx * sfxx) <<< 8) / det;
        q2 = ((n * sfxx - sxx * sf) <<< 24) / det;
        fit.c0       = clamp_q16(q0);
        fit.c2       = clamp_q16(q2);
        fit.singular = 1'b0;
        fit.clipped  = out_of_q16(q0) || out_of_q16(q2);
      end
      pending_fits.push_back(fit);
      clear_set();
    endfunction

    task report_mismatch(input string what);
      if (errors < 100) $display("MISMATCH @%0t ns: %s", $time, what);
      errors++;
    endtask

    task check_fit(input logic [2*COEF_W-1:0] data, input logic [1:0] flags);
      fit_res_t exp_fit;
      if (pending_fits.size() == 0) begin
        report_mismatch($sformatf("fit result with none pending: data %h flags %b",
                                  data, flags));
        return;
      end
      exp_fit = pending_fits.pop_front();
      if (data[COEF_W-1:0] !== exp_fit.c0)
        report_mismatch($sformatf("coef_const got %0d exp %0d",
                                  $signed(data[COEF_W-1:0]), $signed(exp_fit.c0)));
      if (data[2*COEF_W-1:COEF_W] !== exp_fit.c2)
        report_mismatch($sformatf("coef_square got %0d exp %0d",
                                  $signed(data[2*COEF_W-1:COEF_W]), $signed(exp_fit.c2)));
      if (flags[0] !== exp_fit.singular)
        report_mismatch($sformatf("singular got %b exp %b", flags[0], exp_fit.singular));
      if (flags[1] !== exp_fit.clipped)
        report_mismatch($sformatf("clipped got %b exp %b", flags[1], exp_fit.clipped));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  lsq_fit_tracker tracker = new();
  bit             quiet = 1'b0;
  int unsigned    points_sent = 0;
  int unsigned    stall_left = 0;

  always #5 clk = ~clk;

  even_quadratic_lsq_fit_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 200);
  endfunction

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_point(input logic [X_W-1:0] x, input logic [F_W-1:0] f,
                            input logic last_pt);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, f, x};
    s_axis_tlast  <= last_pt;
    do @(posedge clk); while (!s_axis_tready);
    tracker.take_point($signed(x), $signed(f), last_pt);
    points_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_set();
    int unsigned r, len, style, k;
    logic [X_W-1:0] x, mag;
    logic [F_W-1:0] f;
    r = $urandom_range(0, 99);
    if (r < 5) len = 1;
    else if (r < 85) len = $urandom_range(2, POINTS_MAX);
    else len = $urandom_range(POINTS_MAX + 1, POINTS_MAX + 5);
    style = $urandom_range(0, 9);
    mag   = X_W'($urandom_range(0, 2047));
    quiet = ($urandom_range(0, 9) < 2);
    for (k = 0; k < len; k++) begin
      f = F_W'($urandom_range(0, 65535));
      if (style < 5) begin
        x = X_W'($urandom_range(0, 4095));
      end else if (style < 7) begin
        // tiny spread of x drives the coefficients into saturation
        x = X_W'($urandom_range(0, 32) - 16);
      end else if (style < 8) begin
        // equal |x| gives a zero determinant
        x = $urandom_range(0, 1) ? mag : -mag;
      end else begin
        x = X_W'($urandom_range(0, 1024) - 512);
        f = F_W'($urandom_range(0, 8000) - 4000);
      end
      send_point(x, f, k == len - 1);
    end
  endtask

  // result side: random stalls, sampled at the rising edge
  always @(negedge clk) begin
    if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 30) stall_left = pick_gap();
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid && m_axis_tready) tracker.check_fit(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    int unsigned k;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // single point at the negative extremes
    send_point(12'h800, 16'h8000, 1'b1);
    // extremes of x and f in one set
    send_point(12'h7FF, 16'h7FFF, 1'b0);
    send_point(12'h800, 16'h8000, 1'b0);
    send_point(12'hFFF, 16'h0001, 1'b1);
    // equal |x| throughout
    send_point(12'd100, 16'd1, 1'b0);
    send_point(-12'sd100, -16'sd5, 1'b0);
    send_point(12'd100, 16'd300, 1'b1);
    // all points at x = 0
    send_point(12'd0, 16'd5, 1'b0);
    send_point(12'd0, -16'sd5, 1'b1);
    // steep slope saturates negative, then positive
    send_point(12'd1, 16'h7FFF, 1'b0);
    send_point(12'd2, 16'h8000, 1'b1);
    send_point(12'd2, 16'h7FFF, 1'b0);
    send_point(12'd1, 16'h8000, 1'b1);
    // overfull set, last mark on a dropped point
    for (k = 0; k < 10; k++)
      send_point(12'(k * 300 - 1400), 16'(k * 6000 - 27000), k == 9);

    while (points_sent < SET_POINTS) send_random_set();
    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;

    while (tracker.pending_fits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
